// ===== rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque and its storage cells.
// ----------------------------------------------------------------------------
package cdq_pkg;

   // number of entries in the row of cells
   localparam int DEPTH = 16;
   // occupancy width, able to hold DEPTH itself
   localparam int CNT_W = $clog2(DEPTH + 1);
   // word width
   localparam int DATA_W = 32;
   // operation code width
   localparam int OP_W = 3;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_CLEAR      = 3'd4
   } op_type;

   // per-cycle command broadcast to every cell, at most one bit set
   typedef struct packed {
      logic push_back;
      logic push_front;
      logic pop_front;
      logic pop_back;
      logic clear;
   } cell_ctl_type;

endpackage

// ===== rtl/cdq_cell.sv =====
// ----------------------------------------------------------------------------
// cdq_cell
// One storage cell of the deque row. Holds a word and a valid bit; shifts
// towards either neighbour, loads a new back word, drops the back word or clears.
// ----------------------------------------------------------------------------
module cdq_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  cdq_pkg::cell_ctl_type             ctl,
   input  logic signed [cdq_pkg::DATA_W-1:0] push_value,
   input  logic                              left_valid,
   input  logic signed [cdq_pkg::DATA_W-1:0] left_data,
   input  logic                              right_valid,
   input  logic signed [cdq_pkg::DATA_W-1:0] right_data,
   output logic                              valid,
   output logic signed [cdq_pkg::DATA_W-1:0] data,
   output logic signed [cdq_pkg::DATA_W-1:0] tail_data
);

   logic                              valid_ff;
   logic                              valid_in;
   logic signed [cdq_pkg::DATA_W-1:0] data_ff;
   logic signed [cdq_pkg::DATA_W-1:0] data_in;
   logic                              is_tail;

   // this cell holds the back entry when its right neighbour is empty
   assign is_tail = valid_ff & ~right_valid;

   // next contents of the cell
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.push_front) begin
         valid_in = left_valid;
         data_in  = left_data;
      end else if (ctl.pop_front) begin
         valid_in = right_valid;
         data_in  = right_data;
      end else if (ctl.push_back) begin
         if (left_valid && !valid_ff) begin
            valid_in = 1'b1;
            data_in  = push_value;
         end
      end else if (ctl.pop_back) begin
         if (is_tail) begin
            valid_in = 1'b0;
         end
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // word storage, no reset needed
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid     = valid_ff;
   assign data      = data_ff;
   assign tail_data = is_tail ? data_ff : '0;

endmodule

// ===== rtl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed words kept as a row of cells, front at cell 0.
// ----------------------------------------------------------------------------
//
//   channel | ports                                    | direction
//   --------+------------------------------------------+----------
//   request | req_valid req_ready req_op req_push_value | in
//   response| rsp_valid rsp_ready rsp_ok rsp_pop_value  | out
//           | rsp_is_empty rsp_is_full rsp_occupancy    |
//
// One request beat is taken per cycle unless a stalled response holds the
// result register; its response beat appears there on the following cycle.
// The cell row and counter are updated together when a request is taken.
// A stalled response blocks only when the result register is still occupied
// and rsp_ready is low; a beat is taken in the same cycle the old one leaves.
// Reset clears the cell valid bits, the counter and the result valid bit;
// the stored words and the result payload are not cleared.
// ----------------------------------------------------------------------------
module circular_deque (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [cdq_pkg::OP_W-1:0]           req_op,
   input  logic signed [cdq_pkg::DATA_W-1:0]  req_push_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_ok,
   output logic signed [cdq_pkg::DATA_W-1:0]  rsp_pop_value,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full,
   output logic [cdq_pkg::CNT_W-1:0]          rsp_occupancy
);

   localparam logic [cdq_pkg::CNT_W-1:0] FULL_CNT = cdq_pkg::CNT_W'(cdq_pkg::DEPTH);

   logic                              accept;
   logic                              full;
   logic                              empty;
   logic                              ok;
   logic signed [cdq_pkg::DATA_W-1:0] pop_value;
   logic signed [cdq_pkg::DATA_W-1:0] back_value;
   cdq_pkg::cell_ctl_type             ctl;

   logic [cdq_pkg::CNT_W-1:0]         count_ff;
   logic [cdq_pkg::CNT_W-1:0]         count_in;

   logic                              rsp_valid_ff;
   logic                              rsp_ok_ff;
   logic signed [cdq_pkg::DATA_W-1:0] rsp_pop_value_ff;
   logic [cdq_pkg::CNT_W-1:0]         rsp_occupancy_ff;

   logic                              cell_valid [cdq_pkg::DEPTH];
   logic signed [cdq_pkg::DATA_W-1:0] cell_data  [cdq_pkg::DEPTH];
   logic signed [cdq_pkg::DATA_W-1:0] cell_tail  [cdq_pkg::DEPTH];

   // handshake: the result register frees up as its beat leaves
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);

   // operation decode, refusal and next count
   always_comb begin
      ctl      = '0;
      ok       = 1'b0;
      count_in = count_ff;
      unique case (cdq_pkg::op_type'(req_op))
         cdq_pkg::OP_PUSH_BACK: begin
            ok            = ~full;
            ctl.push_back = accept & ~full;
            if (!full) count_in = count_ff + 1'b1;
         end
         cdq_pkg::OP_PUSH_FRONT: begin
            ok             = ~full;
            ctl.push_front = accept & ~full;
            if (!full) count_in = count_ff + 1'b1;
         end
         cdq_pkg::OP_POP_FRONT: begin
            ok            = ~empty;
            ctl.pop_front = accept & ~empty;
            if (!empty) count_in = count_ff - 1'b1;
         end
         cdq_pkg::OP_POP_BACK: begin
            ok           = ~empty;
            ctl.pop_back = accept & ~empty;
            if (!empty) count_in = count_ff - 1'b1;
         end
         cdq_pkg::OP_CLEAR: begin
            ok        = 1'b1;
            ctl.clear = accept;
            count_in  = '0;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // row of cells, front entry in cell 0
   genvar gi;
   generate
      for (gi = 0; gi < cdq_pkg::DEPTH; gi++) begin : g_cell
         logic                              lv;
         logic signed [cdq_pkg::DATA_W-1:0] ld;
         logic                              rv;
         logic signed [cdq_pkg::DATA_W-1:0] rd;

         if (gi == 0) begin : g_first
            assign lv = 1'b1;
            assign ld = req_push_value;
         end else begin : g_mid_l
            assign lv = cell_valid[gi-1];
            assign ld = cell_data[gi-1];
         end

         if (gi == cdq_pkg::DEPTH - 1) begin : g_last
            assign rv = 1'b0;
            assign rd = '0;
         end else begin : g_mid_r
            assign rv = cell_valid[gi+1];
            assign rd = cell_data[gi+1];
         end

         cdq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .push_value  (req_push_value),
            .left_valid  (lv),
            .left_data   (ld),
            .right_valid (rv),
            .right_data  (rd),
            .valid       (cell_valid[gi]),
            .data        (cell_data[gi]),
            .tail_data   (cell_tail[gi])
         );
      end
   endgenerate

   // back word: only the tail cell drives a non-zero value
   always_comb begin
      back_value = '0;
      for (int i = 0; i < cdq_pkg::DEPTH; i++) begin
         back_value = back_value | cell_tail[i];
      end
   end

   // popped word, zero unless a pop succeeds
   always_comb begin
      pop_value = '0;
      if (ctl.pop_front) pop_value = cell_data[0];
      else if (ctl.pop_back) pop_value = back_value;
   end

   // occupancy counter
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ok_ff        <= ok;
         rsp_pop_value_ff <= pop_value;
         rsp_occupancy_ff <= count_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_pop_value = rsp_pop_value_ff;
   assign rsp_occupancy = rsp_occupancy_ff;
   assign rsp_is_empty  = (rsp_occupancy_ff == '0);
   assign rsp_is_full   = (rsp_occupancy_ff == FULL_CNT);

endmodule

// ===== sim/tb_circular_deque.sv =====
// ----------------------------------------------------------------------------
// tb_circular_deque
// Self-checking bench for the circular deque. A short table of directed beats
// (empty and full refusals, extreme words, push front into an empty deque,
// clear, unused op codes) is followed by random phases that lean towards
// pushes, pops or neither so that the deque swings between empty and full. Every
// response beat is compared field by field against its pinned or mirrored
// value, with random idling on both channels and one long response stall.
// ----------------------------------------------------------------------------
module tb_circular_deque;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = cdq_pkg::DEPTH;
   localparam int DATA_W       = cdq_pkg::DATA_W;
   localparam int CNT_W        = cdq_pkg::CNT_W;
   localparam int OP_W         = cdq_pkg::OP_W;
   localparam int IDX_W        = $clog2(DEPTH);
   localparam int TARGET_ITEMS = 1150;
   localparam int NUM_ROWS     = 27;
   localparam int HOLD_CYCLES  = 64;

   // op codes outside the defined set
   localparam logic [OP_W-1:0] OP_UNUSED_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] pop_value;
      logic                     is_empty;
      logic                     is_full;
      logic [CNT_W-1:0]         occupancy;
   } deque_result_type;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] value;
      bit                pinned;
      deque_result_type  want;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [OP_W-1:0]          req_op = '0;
   logic signed [DATA_W-1:0] req_push_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_ok;
   logic signed [DATA_W-1:0] rsp_pop_value;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;
   logic [CNT_W-1:0]         rsp_occupancy;

   // mirror of the deque contents and pointers
   logic [DATA_W-1:0] mirror_store [DEPTH];
   logic [IDX_W-1:0]  mirror_head;
   logic [IDX_W-1:0]  mirror_tail;
   logic [CNT_W-1:0]  mirror_count;

   deque_result_type pending_results [$];
   stim_row_type     directed_rows [NUM_ROWS];

   int  mismatch_count = 0;
   int  requests_sent = 0;
   int  responses_seen = 0;
   int  refused_seen = 0;
   int  full_seen = 0;
   int  hold_cycles = 0;
   bit  send_calm = 1'b0;
   bit  recv_calm = 1'b0;

   always #2 clock = ~clock;

   circular_deque dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .rsp_occupancy  (rsp_occupancy)
   );

   // index arithmetic with wrap
   function automatic logic [IDX_W-1:0] idx_next(logic [IDX_W-1:0] i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
   endfunction

   // empty deque, pointers back at their reset positions
   function automatic void mirror_go_empty();
      mirror_head  = '0;
      mirror_tail  = IDX_W'(DEPTH - 1);
      mirror_count = '0;
   endfunction

   // apply one operation to the mirror and return the response it gives
   function automatic deque_result_type apply_deque_op(logic [OP_W-1:0] op,
                                                       logic [DATA_W-1:0] value);
      deque_result_type r;
      logic             was_full;
      logic             was_empty;
      r         = '0;
      was_full  = (mirror_count >= CNT_W'(DEPTH));
      was_empty = (mirror_count == '0);
      case (op)
         cdq_pkg::OP_PUSH_BACK: begin
            if (!was_full) begin
               mirror_tail = idx_next(mirror_tail);
               mirror_store[mirror_tail] = value;
               mirror_count = mirror_count + 1'b1;
               r.ok = 1'b1;
            end
         end
         cdq_pkg::OP_PUSH_FRONT: begin
            if (!was_full) begin
               mirror_head = idx_prev(mirror_head);
               mirror_store[mirror_head] = value;
               if (was_empty) mirror_tail = mirror_head;
               mirror_count = mirror_count + 1'b1;
               r.ok = 1'b1;
            end
         end
         cdq_pkg::OP_POP_FRONT: begin
            if (!was_empty) begin
               r.pop_value = mirror_store[mirror_head];
               mirror_head = idx_next(mirror_head);
               mirror_count = mirror_count - 1'b1;
               if (mirror_count == '0) mirror_go_empty();
               r.ok = 1'b1;
            end
         end
         cdq_pkg::OP_POP_BACK: begin
            if (!was_empty) begin
               r.pop_value = mirror_store[mirror_tail];
               mirror_tail = idx_prev(mirror_tail);
               mirror_count = mirror_count - 1'b1;
               if (mirror_count == '0) mirror_go_empty();
               r.ok = 1'b1;
            end
         end
         cdq_pkg::OP_CLEAR: begin
            mirror_go_empty();
            r.ok = 1'b1;
         end
         default: ;
      endcase
      r.is_empty  = (mirror_count == '0);
      r.is_full   = (mirror_count >= CNT_W'(DEPTH));
      r.occupancy = mirror_count;
      return r;
   endfunction

   // per-beat wait, none at all during a calm stretch
   function automatic int draw_gap(bit calm);
      if (calm || $urandom_range(0, 2) != 0) return 0;
      return $urandom_range(0, 15);
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // offer one request beat and record its expected response on acceptance
   task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                               input bit pinned, input deque_result_type pinned_want);
      int               gap;
      deque_result_type predicted;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_push_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_deque_op(op, value);
      pending_results.push_back(pinned ? pinned_want : predicted);
      requests_sent++;
   endtask

   task automatic wait_for_drain();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // response side: random idling, one long hold-off on request
   initial begin : response_side
      int               gap;
      deque_result_type got;
      deque_result_type want;
      while (reset) @(posedge clock);
      forever begin
         gap = (hold_cycles > 0) ? hold_cycles : draw_gap(recv_calm);
         hold_cycles = 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got = '{rsp_ok, rsp_pop_value, rsp_is_empty, rsp_is_full, rsp_occupancy};
         responses_seen++;
         if (!got.ok) refused_seen++;
         if (got.is_full) full_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("response beat with nothing pending", got.pop_value, '0);
         end else begin
            want = pending_results.pop_front();
            if (got.ok !== want.ok)
               report_mismatch("ok", DATA_W'(got.ok), DATA_W'(want.ok));
            if (got.pop_value !== want.pop_value)
               report_mismatch("pop_value", got.pop_value, want.pop_value);
            if (got.is_empty !== want.is_empty)
               report_mismatch("is_empty", DATA_W'(got.is_empty), DATA_W'(want.is_empty));
            if (got.is_full !== want.is_full)
               report_mismatch("is_full", DATA_W'(got.is_full), DATA_W'(want.is_full));
            if (got.occupancy !== want.occupancy)
               report_mismatch("occupancy", DATA_W'(got.occupancy), DATA_W'(want.occupancy));
         end
      end
   end

   // run limit
   initial begin : watchdog
      #1_000_000;
      $display("timeout at %0t ns, %0d responses outstanding", $time, pending_results.size());
      $display("tb_circular_deque NOT OK");
      $finish;
   end

   // request side: directed table, then random phases
   initial begin : request_side
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] word;
      int                roll;
      int                push_pct;
      int                phase_len;
      int                phase;

      // refusals on empty, push front into empty, extremes, unused op, full, clear
      directed_rows = '{
         '{cdq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b1, '{1'b0, 32'd0, 1'b1, 1'b0, 5'd0}},
         '{cdq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, '{1'b1, 32'd0, 1'b0, 1'b0, 5'd1}},
         '{cdq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b1,
           '{1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0, 5'd0}},
         '{cdq_pkg::OP_PUSH_BACK,  32'h8000_0000, 1'b1, '{1'b1, 32'd0, 1'b0, 1'b0, 5'd1}},
         '{OP_UNUSED_7,            32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd0, 1'b0, 1'b0, 5'd1}},
         '{cdq_pkg::OP_CLEAR,      32'h1234_5678, 1'b1, '{1'b1, 32'd0, 1'b1, 1'b0, 5'd0}},
         '{cdq_pkg::OP_POP_BACK,   32'h0000_0000, 1'b1, '{1'b0, 32'd0, 1'b1, 1'b0, 5'd0}},
         '{cdq_pkg::OP_PUSH_BACK,  32'h0000_0001, 1'b0, '0},
         '{cdq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFE, 1'b0, '0},
         '{cdq_pkg::OP_PUSH_BACK,  32'h8000_0000, 1'b0, '0},
         '{cdq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0, '0},
         '{cdq_pkg::OP_PUSH_BACK,  32'hA5A5_A5A5, 1'b0, '0},
         '{cdq_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A, 1'b0, '0},
         '{cdq_pkg::OP_PUSH_BACK,  32'h0000_0000, 1'b0, '0},
         '{cdq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, '0},
         '{cdq_pkg::OP_PUSH_BACK,  32'h0F0F_0F0F, 1'b0, '0},
         '{cdq_pkg::OP_PUSH_FRONT, 32'hF0F0_F0F0, 1'b0, '0},
         '{cdq_pkg::OP_PUSH_BACK,  32'h3333_3333, 1'b0, '0},
         '{cdq_pkg::OP_PUSH_FRONT, 32'hCCCC_CCCC, 1'b0, '0},
         '{cdq_pkg::OP_PUSH_BACK,  32'h0000_FFFF, 1'b0, '0},
         '{cdq_pkg::OP_PUSH_FRONT, 32'hFFFF_0000, 1'b0, '0},
         '{cdq_pkg::OP_PUSH_BACK,  32'h1357_9BDF, 1'b0, '0},
         '{cdq_pkg::OP_PUSH_FRONT, 32'h2468_ACE0, 1'b1, '{1'b1, 32'd0, 1'b0, 1'b1, 5'd16}},
         '{cdq_pkg::OP_PUSH_BACK,  32'hDEAD_0001, 1'b1, '{1'b0, 32'd0, 1'b0, 1'b1, 5'd16}},
         '{cdq_pkg::OP_PUSH_FRONT, 32'hDEAD_0002, 1'b1, '{1'b0, 32'd0, 1'b0, 1'b1, 5'd16}},
         '{cdq_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b0, '0},
         '{cdq_pkg::OP_CLEAR,      32'h0000_0000, 1'b1, '{1'b1, 32'd0, 1'b1, 1'b0, 5'd0}}
      };

      mirror_go_empty();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         send_calm = ($urandom_range(0, 1) == 0);
         recv_calm = ($urandom_range(0, 1) == 0);
         send_request(directed_rows[i].op, directed_rows[i].value,
                      directed_rows[i].pinned, directed_rows[i].want);
      end

      // phases leaning to pushes, pops or neither so the deque sweeps full and empty
      phase = 0;
      while (requests_sent < TARGET_ITEMS) begin
         phase_len = $urandom_range(16, 48);
         case ($urandom_range(0, 2))
            0:       push_pct = 85;
            1:       push_pct = 50;
            default: push_pct = 15;
         endcase
         send_calm = ($urandom_range(0, 3) == 0);
         recv_calm = ($urandom_range(0, 3) == 0);
         // long response stall while requests keep coming
         if (phase == 2) begin
            hold_cycles = HOLD_CYCLES;
            send_calm   = 1'b1;
            push_pct    = 85;
         end
         for (int k = 0; k < phase_len; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
               op = cdq_pkg::OP_CLEAR;
            else if (roll < 4)
               op = OP_UNUSED_5 + OP_W'($urandom_range(0, 2));
            else if ($urandom_range(0, 99) < push_pct)
               op = $urandom_range(0, 1) ? cdq_pkg::OP_PUSH_BACK : cdq_pkg::OP_PUSH_FRONT;
            else
               op = $urandom_range(0, 1) ? cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_BACK;
            case ($urandom_range(0, 7))
               0:       word = 32'h8000_0000;
               1:       word = 32'h7FFF_FFFF;
               2:       word = 32'h0000_0000;
               3:       word = 32'hFFFF_FFFF;
               default: word = $urandom;
            endcase
            send_request(op, word, 1'b0, '0);
         end
         // sender pause until the response side has caught up
         if (phase == 1 || $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            wait_for_drain();
         end
         phase++;
      end
      req_valid <= 1'b0;

      wait_for_drain();
      repeat (8) @(posedge clock);

      $display("covered %0d request beats, %0d response beats, %0d refused, %0d at full",
               requests_sent, responses_seen, refused_seen, full_seen);
      if (mismatch_count == 0) begin
         $display("tb_circular_deque OK");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("tb_circular_deque NOT OK");
      end
      $finish;
   end

endmodule
